// ----- hw/rtl/lcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared constants for the LED chaser pattern generator: register indexes,
// pattern mode codes, reset values and field widths.
// ----------------------------------------------------------------------------
package lcp_pkg;

  // default number of LEDs the datapath is sized for
  localparam int DEFAULT_MAX_LEDS = 8;

  // fixed field widths
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int OUT_W    = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS    = 2'd2;

  // pattern mode codes
  localparam logic [3:0] MODE_BLINK     = 4'd0;
  localparam logic [3:0] MODE_PINGPONG  = 4'd1;
  localparam logic [3:0] MODE_IPINGPONG = 4'd2;
  localparam logic [3:0] MODE_CYCLE     = 4'd3;
  localparam logic [3:0] MODE_ICYCLE    = 4'd4;
  localparam logic [3:0] MODE_LOWER     = 4'd5;
  localparam logic [3:0] MODE_RAISE     = 4'd6;
  localparam logic [3:0] MODE_COUNT     = 4'd7;
  localparam logic [3:0] MODE_REVCOUNT  = 4'd8;
  localparam logic [3:0] MODE_CENTER    = 4'd9;
  localparam logic [3:0] MODE_ICENTER   = 4'd10;
  localparam logic [3:0] MODE_CYCLE2    = 4'd11;
  localparam logic [3:0] MODE_CYCLE3    = 4'd12;
  localparam logic [3:0] MODE_ICYCLE2   = 4'd13;
  localparam logic [3:0] MODE_ICYCLE3   = 4'd14;

  // register reset values
  localparam logic [3:0]          RST_PATTERN_MODE = MODE_CYCLE;
  localparam logic [3:0]          RST_LED_COUNT    = 4'd6;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_MS    = 16'd1000;

endpackage : lcp_pkg
`default_nettype wire

// ----- hw/rtl/led_chaser_pattern_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_chaser_pattern_generator
// Maps a millisecond timestamp to an LED chaser pattern and its phase.
//
// Usage:
//   - input channel: in_valid / in_stall with time_ms; one beat per timestamp
//   - output channel: out_valid / out_stall with led_bits and phase_index;
//     exactly one result beat per input beat, in order
//   - config port: cfg_write with cfg_index / cfg_data, written while idle
//   - the chain is step = period / steps (16 bit-serial stages), one
//     multiply for step * steps, time mod (step * steps) (32 stages) and
//     the remainder divided by step (MW stages, where MW is
//     max(16, MAX_LEDS + 1)), then the pattern lookup
//   - throughput is one beat per cycle while the output is not stalled
//   - a stalled output freezes the whole pipeline and raises in_stall;
//     while the last stage is empty the pipeline keeps moving
//   - reset empties the pipeline and loads the register reset values
//     (cycle mode, six LEDs, 1000 ms period)
// ----------------------------------------------------------------------------
module led_chaser_pattern_generator #(
  parameter int MAX_LEDS = lcp_pkg::DEFAULT_MAX_LEDS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [lcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcp_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lcp_pkg::TIME_W-1:0]     time_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [lcp_pkg::OUT_W-1:0]           led_bits,
  output logic [lcp_pkg::OUT_W-1:0]           phase_index
);
  import lcp_pkg::*;

  localparam int NW = $clog2(MAX_LEDS + 1);
  localparam int SW = MAX_LEDS + 1;
  localparam int PW = PERIOD_W;
  localparam int TW = TIME_W;
  localparam int MW = (SW > PW) ? SW : PW;

  typedef struct packed {
    logic [3:0]    mode;
    logic [NW-1:0] n;
    logic [SW-1:0] steps;
  } ctx_t;

  // configuration registers
  logic [3:0]    pattern_mode;
  logic [3:0]    led_count;
  logic [PW-1:0] period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= RST_PATTERN_MODE;
      led_count    <= RST_LED_COUNT;
      period_ms    <= RST_PERIOD_MS;
    end else if (cfg_write) begin
      if (cfg_index == CFG_PATTERN_MODE) pattern_mode <= cfg_data[3:0];
      if (cfg_index == CFG_LED_COUNT)    led_count    <= cfg_data[3:0];
      if (cfg_index == CFG_PERIOD_MS)    period_ms    <= cfg_data[PW-1:0];
    end
  end

  // pipeline advance
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // clamp led count and pick the number of steps for the mode
  ctx_t ctx_in;
  always_comb begin
    int ln;
    ln = int'(led_count);
    if (ln < 2) ln = 2;
    if (ln > MAX_LEDS) ln = MAX_LEDS;
    ctx_in.mode = pattern_mode;
    ctx_in.n    = NW'(ln);
    unique case (pattern_mode)
      MODE_BLINK:                   ctx_in.steps = SW'(2);
      MODE_PINGPONG, MODE_IPINGPONG: ctx_in.steps = SW'(2 * ln - 2);
      MODE_CYCLE, MODE_ICYCLE:      ctx_in.steps = SW'(ln);
      MODE_COUNT, MODE_REVCOUNT:    ctx_in.steps = SW'(1) << ln;
      MODE_CENTER, MODE_ICENTER:    ctx_in.steps = SW'(ln / 2);
      MODE_LOWER, MODE_RAISE, MODE_CYCLE2, MODE_CYCLE3,
      MODE_ICYCLE2, MODE_ICYCLE3:   ctx_in.steps = SW'(ln + 1);
      default:                      ctx_in.steps = SW'(1);
    endcase
  end

  // section a: step = period / steps, one quotient bit per stage
  logic          a_valid [0:PW];
  ctx_t          a_ctx   [0:PW];
  logic [SW-1:0] a_rem   [0:PW];
  logic [PW-1:0] a_num   [0:PW];
  logic [TW-1:0] a_time  [0:PW];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid[0] <= 1'b0;
    end else if (adv) begin
      a_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctx[0]  <= ctx_in;
      a_rem[0]  <= '0;
      a_num[0]  <= period_ms;
      a_time[0] <= time_ms;
    end
  end

  for (genvar k = 0; k < PW; k++) begin : g_a
    logic [SW:0]   sh;
    logic          ge;
    logic [SW-1:0] rem_next;

    always_comb begin
      sh       = {a_rem[k], a_num[k][PW-1]};
      ge       = sh >= {1'b0, a_ctx[k].steps};
      rem_next = ge ? SW'(sh - {1'b0, a_ctx[k].steps}) : sh[SW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid[k+1] <= 1'b0;
      end else if (adv) begin
        a_valid[k+1] <= a_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_ctx[k+1]  <= a_ctx[k];
        a_rem[k+1]  <= rem_next;
        a_num[k+1]  <= {a_num[k][PW-2:0], ge};
        a_time[k+1] <= a_time[k];
      end
    end
  end

  // section b: modulus = step * steps, then time mod modulus bit by bit
  logic          b_valid [0:TW];
  ctx_t          b_ctx   [0:TW];
  logic [PW-1:0] b_step  [0:TW];
  logic [MW-1:0] b_mod   [0:TW];
  logic [MW-1:0] b_rem   [0:TW];
  logic [TW-1:0] b_num   [0:TW];

  // zero step length saturates to one
  logic [PW-1:0] step_sat;
  assign step_sat = (a_num[PW] == '0) ? PW'(1) : a_num[PW];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid[0] <= 1'b0;
    end else if (adv) begin
      b_valid[0] <= a_valid[PW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctx[0]  <= a_ctx[PW];
      b_step[0] <= step_sat;
      b_mod[0]  <= MW'(step_sat) * MW'(a_ctx[PW].steps);
      b_rem[0]  <= '0;
      b_num[0]  <= a_time[PW];
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_b
    logic [MW:0]   sh;
    logic          ge;
    logic [MW-1:0] rem_next;

    always_comb begin
      sh       = {b_rem[k], b_num[k][TW-1]};
      ge       = sh >= {1'b0, b_mod[k]};
      rem_next = ge ? MW'(sh - {1'b0, b_mod[k]}) : sh[MW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        b_valid[k+1] <= 1'b0;
      end else if (adv) begin
        b_valid[k+1] <= b_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        b_ctx[k+1]  <= b_ctx[k];
        b_step[k+1] <= b_step[k];
        b_mod[k+1]  <= b_mod[k];
        b_rem[k+1]  <= rem_next;
        b_num[k+1]  <= {b_num[k][TW-2:0], 1'b0};
      end
    end
  end

  // section c: phase = remainder / step, one quotient bit per stage
  logic          c_valid [1:MW];
  ctx_t          c_ctx   [1:MW];
  logic [PW-1:0] c_step  [1:MW];
  logic [PW-1:0] c_rem   [1:MW];
  logic [MW-1:0] c_num   [1:MW];

  for (genvar k = 1; k <= MW; k++) begin : g_c
    logic          s_valid;
    ctx_t          s_ctx;
    logic [PW-1:0] s_step;
    logic [PW-1:0] s_rem;
    logic [MW-1:0] s_num;
    logic [PW:0]   sh;
    logic          ge;
    logic [PW-1:0] rem_next;

    if (k == 1) begin : g_src
      always_comb begin
        s_valid = b_valid[TW];
        s_ctx   = b_ctx[TW];
        s_step  = b_step[TW];
        s_rem   = '0;
        s_num   = b_rem[TW];
      end
    end else begin : g_src
      always_comb begin
        s_valid = c_valid[k-1];
        s_ctx   = c_ctx[k-1];
        s_step  = c_step[k-1];
        s_rem   = c_rem[k-1];
        s_num   = c_num[k-1];
      end
    end

    always_comb begin
      sh       = {s_rem, s_num[MW-1]};
      ge       = sh >= {1'b0, s_step};
      rem_next = ge ? PW'(sh - {1'b0, s_step}) : sh[PW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[k] <= 1'b0;
      end else if (adv) begin
        c_valid[k] <= s_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c_ctx[k]  <= s_ctx;
        c_step[k] <= s_step;
        c_rem[k]  <= rem_next;
        c_num[k]  <= {s_num[MW-2:0], ge};
      end
    end
  end

  // single led at a position, nothing outside the row
  function automatic logic [MAX_LEDS-1:0] bit_at(input int pos);
    logic [MAX_LEDS-1:0] r;
    if (pos < 0 || pos >= MAX_LEDS) r = '0;
    else r = MAX_LEDS'(1) << pos;
    return r;
  endfunction

  // pattern lookup
  logic [OUT_W-1:0] led_next;
  logic [OUT_W-1:0] phase_next;

  always_comb begin
    int                  sn;
    int                  sp;
    logic [SW-1:0]       ph;
    logic [3:0]          md;
    logic [MAX_LEDS-1:0] mask;
    logic [MAX_LEDS-1:0] bits;
    ph   = c_num[MW][SW-1:0];
    md   = c_ctx[MW].mode;
    sn   = int'(c_ctx[MW].n);
    sp   = int'(ph);
    mask = MAX_LEDS'((33'd1 << sn) - 33'd1);
    unique case (md)
      MODE_BLINK: bits = (ph != '0) ? mask : '0;
      MODE_PINGPONG, MODE_IPINGPONG: begin
        bits = (sp < sn) ? bit_at(sn - 1 - sp) : bit_at(sp - sn + 1);
        if (md == MODE_IPINGPONG) bits = bits ^ mask;
      end
      MODE_CYCLE, MODE_ICYCLE: begin
        bits = bit_at(sn - 1 - sp);
        if (md == MODE_ICYCLE) bits = bits ^ mask;
      end
      MODE_LOWER: bits = mask >> sp;
      MODE_RAISE: bits = ~(mask >> sp);
      MODE_COUNT: bits = MAX_LEDS'(ph);
      MODE_REVCOUNT: bits = mask - MAX_LEDS'(ph);
      MODE_CENTER, MODE_ICENTER: begin
        bits = bit_at(sn - 1 - sp) | bit_at(sp);
        if (md == MODE_ICENTER) bits = bits ^ mask;
      end
      MODE_CYCLE2, MODE_CYCLE3, MODE_ICYCLE2, MODE_ICYCLE3: begin
        if (sp < sn) begin
          bits = bit_at(sn - 1 - sp) | bit_at(sn - 2 - sp);
          if (md == MODE_CYCLE3 || md == MODE_ICYCLE3) bits = bits | bit_at(sn - 3 - sp);
          if (md == MODE_ICYCLE2 || md == MODE_ICYCLE3) bits = ~bits;
        end else begin
          bits = (md == MODE_ICYCLE2 || md == MODE_ICYCLE3) ? mask : '0;
        end
      end
      default: begin
        bits = '0;
        ph   = '0;
      end
    endcase
    led_next   = OUT_W'(bits & mask);
    phase_next = OUT_W'(ph);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      led_bits    <= led_next;
      phase_index <= phase_next;
    end
  end

endmodule : led_chaser_pattern_generator
`default_nettype wire

// ----- hw/rtl/lcp_checks.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_checks
// Port-level checks for the LED chaser pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module lcp_checks (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [lcp_pkg::OUT_W-1:0]     led_bits,
  input wire logic [lcp_pkg::OUT_W-1:0]     phase_index
);
  import lcp_pkg::*;

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(led_bits) && $stable(phase_index))
    else $error("result payload changed while stalled");

  // input only backs up when the output is blocked
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // a stalled input beat stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input beat dropped while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule : lcp_checks

bind led_chaser_pattern_generator lcp_checks u_lcp_checks (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .led_bits    (led_bits),
  .phase_index (phase_index)
);
`default_nettype wire
